// ===== sv/tcbs_pkg.sv =====
// Shared types and codes for the two client burst scheduler.
`default_nettype none

package tcbs_pkg;

    localparam int CFG_WIDTH = 16;
    localparam int CFG_INDEX_WIDTH = 3;

    localparam logic [1:0] PH_READY = 2'd0;
    localparam logic [1:0] PH_RUN   = 2'd1;
    localparam logic [1:0] PH_WAIT  = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    localparam logic [1:0] POL_FCFS  = 2'd0;
    localparam logic [1:0] POL_SJF   = 2'd1;
    localparam logic [1:0] POL_PSJF  = 2'd2;
    localparam logic [1:0] POL_RR    = 2'd3;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_POLICY     = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_QUANTUM    = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_C1_FIRST   = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_C1_IO      = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_C1_SECOND  = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_C2_FIRST   = 3'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_C2_IO      = 3'd6;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_C2_SECOND  = 3'd7;

    typedef struct packed {
        logic [1:0]           policy;
        logic [CFG_WIDTH-1:0] quantum;
        logic [CFG_WIDTH-1:0] c1_first_burst;
        logic [CFG_WIDTH-1:0] c1_io_wait;
        logic [CFG_WIDTH-1:0] c1_second_burst;
        logic [CFG_WIDTH-1:0] c2_first_burst;
        logic [CFG_WIDTH-1:0] c2_io_wait;
        logic [CFG_WIDTH-1:0] c2_second_burst;
    } cfg_t;

    typedef struct packed {
        logic [1:0] c1_status;
        logic [1:0] c2_status;
        logic       all_done;
    } status_t;

endpackage

`default_nettype wire

// ===== sv/tcbs_tick.sv =====
// Next-state logic for one scheduler tick: restart, completion, expiry, IO return, dispatch.
`default_nettype none

module tcbs_tick #(
    parameter int COUNT_WIDTH = 16
) (
    input  tcbs_pkg::cfg_t          cfg,
    input  logic                    restart,
    input  logic [1:0]              c1_phase,
    input  logic [1:0]              c2_phase,
    input  logic [COUNT_WIDTH-1:0]  c1_cpu_left,
    input  logic [COUNT_WIDTH-1:0]  c2_cpu_left,
    input  logic [COUNT_WIDTH-1:0]  c1_io_left,
    input  logic [COUNT_WIDTH-1:0]  c2_io_left,
    input  logic [COUNT_WIDTH-1:0]  slice_left,
    output logic [1:0]              c1_phase_next,
    output logic [1:0]              c2_phase_next,
    output logic [COUNT_WIDTH-1:0]  c1_cpu_left_next,
    output logic [COUNT_WIDTH-1:0]  c2_cpu_left_next,
    output logic [COUNT_WIDTH-1:0]  c1_io_left_next,
    output logic [COUNT_WIDTH-1:0]  c2_io_left_next,
    output logic [COUNT_WIDTH-1:0]  slice_left_next,
    output tcbs_pkg::status_t       status
);

    import tcbs_pkg::*;

    function automatic logic [COUNT_WIDTH-1:0] dec_sat(input logic [COUNT_WIDTH-1:0] v);
        dec_sat = (v == '0) ? v : v - 1'b1;
    endfunction

    always_comb
    begin
        logic [1:0]             p1;
        logic [1:0]             p2;
        logic [COUNT_WIDTH-1:0] cpu1;
        logic [COUNT_WIDTH-1:0] cpu2;
        logic [COUNT_WIDTH-1:0] io1;
        logic [COUNT_WIDTH-1:0] io2;
        logic [COUNT_WIDTH-1:0] slice;
        logic [COUNT_WIDTH-1:0] quantum;
        logic                   sjf;

        quantum = COUNT_WIDTH'(cfg.quantum);
        sjf     = (cfg.policy == POL_SJF) || (cfg.policy == POL_PSJF);

        p1    = c1_phase;
        p2    = c2_phase;
        cpu1  = c1_cpu_left;
        cpu2  = c2_cpu_left;
        io1   = c1_io_left;
        io2   = c2_io_left;
        slice = slice_left;

        if (restart)
        begin
            p1    = PH_READY;
            p2    = PH_READY;
            cpu1  = COUNT_WIDTH'(cfg.c1_first_burst);
            io1   = COUNT_WIDTH'(cfg.c1_io_wait);
            cpu2  = COUNT_WIDTH'(cfg.c2_first_burst);
            io2   = COUNT_WIDTH'(cfg.c2_io_wait);
            slice = '0;
        end

        // burst completion, client 1 first
        if (p1 == PH_RUN && cpu1 == '0)
            p1 = (io1 == '0) ? PH_DONE : PH_WAIT;
        else if (p2 == PH_RUN && cpu2 == '0)
            p2 = (io2 == '0) ? PH_DONE : PH_WAIT;

        // slice expiry
        if (cfg.policy == POL_RR)
        begin
            if (p1 == PH_RUN && slice == '0)
            begin
                p1 = PH_READY;
                if (p2 == PH_READY)
                begin
                    p2    = PH_RUN;
                    slice = quantum;
                end
            end
            if (p2 == PH_RUN && slice == '0)
            begin
                p2 = PH_READY;
                if (p1 == PH_READY)
                begin
                    p1    = PH_RUN;
                    slice = quantum;
                end
            end
        end

        // IO return
        if (p1 == PH_WAIT && io1 == '0)
        begin
            p1   = PH_READY;
            cpu1 = COUNT_WIDTH'(cfg.c1_second_burst);
        end
        if (p2 == PH_WAIT && io2 == '0)
        begin
            p2   = PH_READY;
            cpu2 = COUNT_WIDTH'(cfg.c2_second_burst);
        end

        // dispatch
        if (p1 == PH_READY && p2 == PH_READY)
        begin
            if (sjf && cpu1 > cpu2)
                p2 = PH_RUN;
            else
                p1 = PH_RUN;
            slice = quantum;
        end
        else if (p1 == PH_READY && p2 != PH_RUN)
        begin
            p1    = PH_RUN;
            slice = quantum;
        end
        else if (p2 == PH_READY && p1 != PH_RUN)
        begin
            p2    = PH_RUN;
            slice = quantum;
        end
        else if (cfg.policy == POL_PSJF && p1 == PH_READY && cpu1 < cpu2)
        begin
            p2    = PH_READY;
            p1    = PH_RUN;
            slice = quantum;
        end
        else if (cfg.policy == POL_PSJF && p2 == PH_READY && cpu2 < cpu1)
        begin
            p1    = PH_READY;
            p2    = PH_RUN;
            slice = quantum;
        end

        status.c1_status = p1;
        status.c2_status = p2;
        status.all_done  = (p1 == PH_DONE) && (p2 == PH_DONE);

        c1_phase_next    = p1;
        c2_phase_next    = p2;
        slice_left_next  = dec_sat(slice);
        c1_cpu_left_next = (p1 == PH_RUN)  ? dec_sat(cpu1) : cpu1;
        c1_io_left_next  = (p1 == PH_WAIT) ? dec_sat(io1)  : io1;
        c2_cpu_left_next = (p2 == PH_RUN)  ? dec_sat(cpu2) : cpu2;
        c2_io_left_next  = (p2 == PH_WAIT) ? dec_sat(io2)  : io2;
    end

endmodule

`default_nettype wire

// ===== sv/two_client_burst_scheduler.sv =====
// Top level: config registers, scheduler state registers and the result register.
// Latency: a result is valid the cycle after its input transfer.
// Throughput: one tick per cycle while in_ready holds; the state registers close the loop in one pass.
// A new input is taken whenever the result register is empty or being read.
// Reset: config returns to policy FCFS and all lengths 1, both clients ready
// with counters at 1, slice counter at 0, result register empty.
`default_nettype none

module two_client_burst_scheduler #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write,
    input  logic [tcbs_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [tcbs_pkg::CFG_WIDTH-1:0]         cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   restart,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [1:0]                             c1_status,
    output logic [1:0]                             c2_status,
    output logic                                   all_done
);

    import tcbs_pkg::*;

    cfg_t                   cfg_reg;
    logic [1:0]             c1_phase_reg;
    logic [1:0]             c2_phase_reg;
    logic [COUNT_WIDTH-1:0] c1_cpu_left_reg;
    logic [COUNT_WIDTH-1:0] c2_cpu_left_reg;
    logic [COUNT_WIDTH-1:0] c1_io_left_reg;
    logic [COUNT_WIDTH-1:0] c2_io_left_reg;
    logic [COUNT_WIDTH-1:0] slice_left_reg;
    logic [1:0]             c1_phase_next;
    logic [1:0]             c2_phase_next;
    logic [COUNT_WIDTH-1:0] c1_cpu_left_next;
    logic [COUNT_WIDTH-1:0] c2_cpu_left_next;
    logic [COUNT_WIDTH-1:0] c1_io_left_next;
    logic [COUNT_WIDTH-1:0] c2_io_left_next;
    logic [COUNT_WIDTH-1:0] slice_left_next;
    status_t                status_next;
    status_t                status_reg;
    logic                   out_valid_reg;
    logic                   in_xfer;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.policy          <= POL_FCFS;
            cfg_reg.quantum         <= CFG_WIDTH'(1);
            cfg_reg.c1_first_burst  <= CFG_WIDTH'(1);
            cfg_reg.c1_io_wait      <= CFG_WIDTH'(1);
            cfg_reg.c1_second_burst <= CFG_WIDTH'(1);
            cfg_reg.c2_first_burst  <= CFG_WIDTH'(1);
            cfg_reg.c2_io_wait      <= CFG_WIDTH'(1);
            cfg_reg.c2_second_burst <= CFG_WIDTH'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_POLICY:    cfg_reg.policy          <= cfg_data[1:0];
                REG_QUANTUM:   cfg_reg.quantum         <= cfg_data;
                REG_C1_FIRST:  cfg_reg.c1_first_burst  <= cfg_data;
                REG_C1_IO:     cfg_reg.c1_io_wait      <= cfg_data;
                REG_C1_SECOND: cfg_reg.c1_second_burst <= cfg_data;
                REG_C2_FIRST:  cfg_reg.c2_first_burst  <= cfg_data;
                REG_C2_IO:     cfg_reg.c2_io_wait      <= cfg_data;
                REG_C2_SECOND: cfg_reg.c2_second_burst <= cfg_data;
                default:       cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    tcbs_tick #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_tick (
        .cfg              (cfg_reg),
        .restart          (restart),
        .c1_phase         (c1_phase_reg),
        .c2_phase         (c2_phase_reg),
        .c1_cpu_left      (c1_cpu_left_reg),
        .c2_cpu_left      (c2_cpu_left_reg),
        .c1_io_left       (c1_io_left_reg),
        .c2_io_left       (c2_io_left_reg),
        .slice_left       (slice_left_reg),
        .c1_phase_next    (c1_phase_next),
        .c2_phase_next    (c2_phase_next),
        .c1_cpu_left_next (c1_cpu_left_next),
        .c2_cpu_left_next (c2_cpu_left_next),
        .c1_io_left_next  (c1_io_left_next),
        .c2_io_left_next  (c2_io_left_next),
        .slice_left_next  (slice_left_next),
        .status           (status_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_phase_reg    <= PH_READY;
            c2_phase_reg    <= PH_READY;
            c1_cpu_left_reg <= COUNT_WIDTH'(1);
            c2_cpu_left_reg <= COUNT_WIDTH'(1);
            c1_io_left_reg  <= COUNT_WIDTH'(1);
            c2_io_left_reg  <= COUNT_WIDTH'(1);
            slice_left_reg  <= '0;
        end
        else if (in_xfer)
        begin
            c1_phase_reg    <= c1_phase_next;
            c2_phase_reg    <= c2_phase_next;
            c1_cpu_left_reg <= c1_cpu_left_next;
            c2_cpu_left_reg <= c2_cpu_left_next;
            c1_io_left_reg  <= c1_io_left_next;
            c2_io_left_reg  <= c2_io_left_next;
            slice_left_reg  <= slice_left_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_xfer)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
            status_reg <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign c1_status = status_reg.c1_status;
    assign c2_status = status_reg.c2_status;
    assign all_done  = status_reg.all_done;

endmodule

`default_nettype wire
